// ===== design/swr_pkg.sv =====
// ---------------------------------------------------------------------------
// swr_pkg: shared types and constants for the stop-and-wait receiver
// Event and result words, configuration fields, phase and action codes.
// ---------------------------------------------------------------------------
package swr_pkg;

	localparam int SEQ_MOD     = 32;
	localparam int MAX_PAYLOAD = 63;

	localparam int FUNC_W = 2;
	localparam int FSEQ_W = 5;
	localparam int TYPE_W = 4;
	localparam int PLEN_W = 6;
	localparam int ACT_W  = 3;
	localparam int CAP_W  = 24;
	localparam int TMO_W  = 8;
	localparam int SEQ_W  = $clog2(SEQ_MOD);

	localparam int QUEUE_DEPTH = 2;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_CAPACITY  = 2'd0;
	localparam logic [1:0] REG_MAX_TMO   = 2'd1;
	localparam logic [1:0] REG_LAST_TYPE = 2'd2;

	localparam logic [CAP_W-1:0]  CAPACITY_RST  = 24'd10485760;
	localparam logic [TMO_W-1:0]  MAX_TMO_RST   = 8'd8;
	localparam logic [TYPE_W-1:0] LAST_TYPE_RST = 4'd15;

	localparam logic [FUNC_W-1:0] FUNC_START   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PARSE   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_FRAME   = 2'd3;

	localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ACK   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_NACK  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_FAIL  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_START = 3'd4;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RUN  = 2'd1,
		PH_DONE = 2'd2,
		PH_FAIL = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		EV_START,
		EV_TIMEOUT,
		EV_PARSE_FAIL,
		EV_FRAME
	} ev_kind_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [FSEQ_W-1:0] frame_seq;
		logic [TYPE_W-1:0] frame_type;
		logic [PLEN_W-1:0] payload_len;
	} ev_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [FSEQ_W-1:0] reply_seq;
		logic              accept_data;
		logic [CAP_W-1:0]  write_offset;
		logic [CAP_W-1:0]  received_total;
		logic              done_res;
	} res_t;

	typedef struct packed {
		logic [CAP_W-1:0]  buffer_capacity;
		logic [TMO_W-1:0]  max_timeouts;
		logic [TYPE_W-1:0] last_type;
	} cfg_t;

	// classified event held in the queue
	typedef struct packed {
		ev_kind_t          kind;
		logic              oversized;
		logic [FSEQ_W-1:0] frame_seq;
		logic [TYPE_W-1:0] frame_type;
		logic [PLEN_W-1:0] payload_len;
	} qent_t;

endpackage

// ===== design/stop_and_wait_receiver_unit.sv =====
// A result word is registered: an accepted event is written into the queue, then the
// state update writes its result into the output register.
// Throughput: one event per cycle; it stalls while a result awaits res_ready.
// A two-entry queue sits between intake and state update, so each side stalls alone.
// Reset: transfer state clears to idle, registers load their defaults; no clearing pass.
// ---------------------------------------------------------------------------
// stop_and_wait_receiver_unit: receiver side of a stop-and-wait transfer
// Tracks sequence, timeouts and bytes taken; issues ACK, NACK, fail and start.
// ---------------------------------------------------------------------------
module stop_and_wait_receiver_unit #(
	parameter int QUEUE_DEPTH = swr_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ev_valid,
	output logic                        ev_ready,
	input  swr_pkg::ev_t                ev_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output swr_pkg::res_t               res_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swr_pkg::PADDR_W-1:0] paddr,
	input  logic [swr_pkg::PDATA_W-1:0] pwdata,
	output logic [swr_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import swr_pkg::*;

	cfg_t  cfg;
	qent_t q_wdata;
	qent_t q_head;
	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_head_valid;

	swr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	swr_front u_front (
		.ev_valid (ev_valid),
		.ev_ready (ev_ready),
		.ev_data  (ev_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	swr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wdata      (q_wdata),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	swr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

endmodule

// ===== design/swr_cfg.sv =====
// ---------------------------------------------------------------------------
// swr_cfg: configuration register file
// APB-style write and read of capacity, timeout limit and final frame type.
// ---------------------------------------------------------------------------
module swr_cfg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [swr_pkg::PADDR_W-1:0] paddr,
	input  logic [swr_pkg::PDATA_W-1:0] pwdata,
	output logic [swr_pkg::PDATA_W-1:0] prdata,
	output logic                   pready,
	output swr_pkg::cfg_t          cfg
);
	import swr_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_capacity <= CAPACITY_RST;
			cfg_q.max_timeouts    <= MAX_TMO_RST;
			cfg_q.last_type       <= LAST_TYPE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CAPACITY:  cfg_q.buffer_capacity <= pwdata[CAP_W-1:0];
				REG_MAX_TMO:   cfg_q.max_timeouts    <= pwdata[TMO_W-1:0];
				REG_LAST_TYPE: cfg_q.last_type       <= pwdata[TYPE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CAPACITY:  prdata = PDATA_W'(cfg_q.buffer_capacity);
			REG_MAX_TMO:   prdata = PDATA_W'(cfg_q.max_timeouts);
			REG_LAST_TYPE: prdata = PDATA_W'(cfg_q.last_type);
			default:       prdata = '0;
		endcase
	end

endmodule

// ===== design/swr_front.sv =====
// ---------------------------------------------------------------------------
// swr_front: event intake
// Accept event words, classify them and push them into the queue.
// ---------------------------------------------------------------------------
module swr_front (
	input  logic           ev_valid,
	output logic           ev_ready,
	input  swr_pkg::ev_t   ev_data,
	input  logic           q_full,
	output logic           q_push,
	output swr_pkg::qent_t q_wdata
);
	import swr_pkg::*;

	assign ev_ready = ~q_full;
	assign q_push   = ev_valid & ~q_full;

	always_comb begin
		unique case (ev_data.func)
			FUNC_START:   q_wdata.kind = EV_START;
			FUNC_TIMEOUT: q_wdata.kind = EV_TIMEOUT;
			FUNC_PARSE:   q_wdata.kind = EV_PARSE_FAIL;
			FUNC_FRAME:   q_wdata.kind = EV_FRAME;
			default:      q_wdata.kind = EV_FRAME;
		endcase
		// an in-sequence frame whose payload exceeds MAX_PAYLOAD fails the transfer
		q_wdata.oversized   = ({2'b00, ev_data.payload_len} > 8'(MAX_PAYLOAD));
		q_wdata.frame_seq   = ev_data.frame_seq;
		q_wdata.frame_type  = ev_data.frame_type;
		q_wdata.payload_len = ev_data.payload_len;
	end

endmodule

// ===== design/swr_queue.sv =====
// ---------------------------------------------------------------------------
// swr_queue: short FIFO between intake and state update
// Small circular buffer; push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
module swr_queue #(
	parameter int DEPTH = swr_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  swr_pkg::qent_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output swr_pkg::qent_t head
);
	import swr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	qent_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/swr_back.sv =====
// ---------------------------------------------------------------------------
// swr_back: transfer state update
// While not stalled, apply one queued event per cycle; register the result.
// ---------------------------------------------------------------------------
module swr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  swr_pkg::cfg_t  cfg,
	input  logic           head_valid,
	input  swr_pkg::qent_t head,
	output logic           pop,
	output logic           res_valid,
	input  logic           res_ready,
	output swr_pkg::res_t  res_data
);
	import swr_pkg::*;

	phase_t            phase_q, phase_d;
	logic [SEQ_W-1:0]  exp_q, exp_d;
	logic [TMO_W-1:0]  run_q, run_d;
	logic [CAP_W-1:0]  bytes_q, bytes_d;
	logic              out_valid_q;
	res_t              out_q;
	res_t              res_d;

	logic [SEQ_W-1:0]  prev_seq;
	logic [SEQ_W-1:0]  next_seq;
	logic [TMO_W-1:0]  run_inc;
	logic [CAP_W:0]    bytes_sum;
	logic              overflow;

	// advance when the output register is free or being drained
	assign pop       = head_valid & (~out_valid_q | res_ready);
	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	assign prev_seq  = (exp_q == '0) ? SEQ_W'(SEQ_MOD - 1) : exp_q - SEQ_W'(1);
	assign next_seq  = (exp_q == SEQ_W'(SEQ_MOD - 1)) ? '0 : exp_q + SEQ_W'(1);
	assign run_inc   = (run_q == '1) ? run_q : run_q + TMO_W'(1);
	assign bytes_sum = {1'b0, bytes_q} + (CAP_W + 1)'(head.payload_len);
	assign overflow  = bytes_sum > {1'b0, cfg.buffer_capacity};

	always_comb begin
		phase_d = phase_q;
		exp_d   = exp_q;
		run_d   = run_q;
		bytes_d = bytes_q;
		res_d   = '0;
		res_d.action = ACT_NONE;

		if (head.kind == EV_START) begin
			phase_d = PH_RUN;
			exp_d   = '0;
			run_d   = '0;
			bytes_d = '0;
			res_d.action = ACT_START;
		end else if (phase_q == PH_RUN) begin
			unique case (head.kind)
				EV_TIMEOUT: begin
					run_d = run_inc;
					if (run_inc >= cfg.max_timeouts) begin
						phase_d = PH_FAIL;
						res_d.action = ACT_FAIL;
					end
				end
				EV_PARSE_FAIL: begin
					run_d   = '0;
					phase_d = PH_FAIL;
					res_d.action = ACT_FAIL;
				end
				EV_FRAME: begin
					run_d = '0;
					priority if (head.frame_seq != FSEQ_W'(exp_q)) begin
						if (head.frame_seq == FSEQ_W'(prev_seq)) begin
							res_d.action    = ACT_ACK;
							res_d.reply_seq = head.frame_seq;
						end else begin
							res_d.action    = ACT_NACK;
							res_d.reply_seq = FSEQ_W'(exp_q);
						end
					end else if (head.oversized || overflow) begin
						phase_d = PH_FAIL;
						res_d.action = ACT_FAIL;
					end else begin
						res_d.accept_data  = 1'b1;
						res_d.write_offset = bytes_q;
						res_d.action       = ACT_ACK;
						res_d.reply_seq    = FSEQ_W'(exp_q);
						bytes_d            = bytes_sum[CAP_W-1:0];
						exp_d              = next_seq;
						if (head.frame_type == cfg.last_type) begin
							phase_d        = PH_DONE;
							res_d.done_res = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
		res_d.received_total = bytes_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			exp_q   <= '0;
			run_q   <= '0;
			bytes_q <= '0;
		end else if (pop) begin
			phase_q <= phase_d;
			exp_q   <= exp_d;
			run_q   <= run_d;
			bytes_q <= bytes_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res_d;
		end
	end

endmodule
